>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the lowest common ancestor engine.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define BL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, during reset as well.
`define BL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/bl_lca_pkg.sv
// Shared constants and helpers of the binary-lifting lowest common ancestor engine.
// Used by the channel interfaces and the top level; depends on nothing.
package bl_lca_pkg;

    // Field widths of the input and result words.
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 10;
    // Widest node slot that the largest node count needs.
    localparam int MAX_NODE_W = 17;

    // Default sizing of the node store.
    localparam int NODE_COUNT_DEF = 1024;
    localparam int LEVELS_DEF     = 10;

    // Codes of the kind field.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Reduce a node number modulo the node count by conditional subtraction of
    // shifted copies of the count. With a constant count most steps fold away.
    function automatic logic [MAX_NODE_W-1:0] node_slot(input logic [NODE_W-1:0] node,
                                                         input int unsigned count);
        logic [31:0] rem;
        rem = 32'(node);
        for (int k = NODE_W - 1; k >= 0; k--) begin
            if (rem >= (32'(count) << k)) begin
                rem = rem - (32'(count) << k);
            end
        end
        return MAX_NODE_W'(rem);
    endfunction

endpackage

>>> design/bl_lca_ifs.sv
// Valid/ready channel interfaces for the input and result words of the engine.
// Depends on bl_lca_pkg for the field widths.
interface bl_lca_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [bl_lca_pkg::NODE_W-1:0]  node_a;
    logic [bl_lca_pkg::NODE_W-1:0]  node_b;
    logic [bl_lca_pkg::DEPTH_W-1:0] node_depth;

    modport source (output valid, kind, node_a, node_b, node_depth, input ready);
    modport sink   (input valid, kind, node_a, node_b, node_depth, output ready);
endinterface

interface bl_lca_out_if;
    logic                          valid;
    logic                          ready;
    logic [bl_lca_pkg::NODE_W-1:0] ancestor;

    modport source (output valid, ancestor, input ready);
    modport sink   (input valid, ancestor, output ready);
endinterface

>>> design/binary_lifting_lca_top.sv
// Binary-lifting lowest common ancestor engine. An add word stores a node's depth and
// fills its ancestor row, one ancestor level per read-and-write turn of the ancestor
// memory, before the next word can be taken. A query word is worked in parts: two
// depth reads in the same cycle, one lifting step per level (with a read of the
// ancestor memory where the depth difference has that bit set) and, unless the lifted
// node meets the other node, a read and a compare per level of the joint descent and
// a final parent read. The read data of both memories is registered before it is
// used. One word is worked on at a time; a finished answer waits in the output
// register while the next word is accepted, and an answer that finds that register
// still full waits until it empties. Memories are not cleared: nodes must be added,
// parents first, before a query or an add reads them.
module binary_lifting_lca_top #(
    parameter int NODE_COUNT = bl_lca_pkg::NODE_COUNT_DEF,
    parameter int LEVELS     = bl_lca_pkg::LEVELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bl_lca_in_if.sink    i_in,
    bl_lca_out_if.source o_out
);

`include "assert_macros.svh"

    localparam int NW        = $clog2(NODE_COUNT);
    localparam int LVW       = $clog2(LEVELS);
    localparam int TBL_DEPTH = NODE_COUNT * LEVELS;
    localparam int TW        = $clog2(TBL_DEPTH);
    localparam logic [LVW-1:0] LVL_TOP = LVW'(LEVELS - 1);
    localparam logic [LVW-1:0] LVL_ONE = LVW'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_ADD_WAIT,
        ST_DEPTH_WAIT,
        ST_LIFT,
        ST_LIFT_WAIT,
        ST_CHECK,
        ST_DESC,
        ST_DESC_WAIT,
        ST_FINAL_RD,
        ST_FINAL_WAIT,
        ST_DONE
    } t_state;

    // Address of one entry of the ancestor memory: row of the node, column of the level.
    function automatic logic [TW-1:0] tbl_addr(input logic [NW-1:0] row,
                                               input logic [LVW-1:0] lvl);
        return TW'(row) * TW'(LEVELS) + TW'(lvl);
    endfunction

    // Memories and their registered read data.
    logic [bl_lca_pkg::NODE_W-1:0]  mem_tbl [TBL_DEPTH];
    logic [bl_lca_pkg::DEPTH_W-1:0] mem_dep [NODE_COUNT];
    logic [bl_lca_pkg::NODE_W-1:0]  r_tbl_rd_a, r_tbl_rd_b;
    logic [bl_lca_pkg::DEPTH_W-1:0] r_dep_rd_a, r_dep_rd_b;

    logic                           tbl_we;
    logic [TW-1:0]                  tbl_waddr, tbl_raddr_a, tbl_raddr_b;
    logic [bl_lca_pkg::NODE_W-1:0]  tbl_wdata;
    logic                           dep_we;

    // Control and payload registers with their next values.
    t_state                        r_state, n_state;
    logic [LVW-1:0]                r_lvl, n_lvl;
    logic [NW-1:0]                 r_node, n_node;
    logic [bl_lca_pkg::NODE_W-1:0] r_cur, n_cur;
    logic                          r_fwd, n_fwd;
    logic [NW-1:0]                 r_u, n_u;
    logic [NW-1:0]                 r_v, n_v;
    logic [LEVELS-1:0]             r_diff, n_diff;
    logic [bl_lca_pkg::NODE_W-1:0] r_res, n_res;
    logic                          r_out_valid, n_out_valid;
    logic [bl_lca_pkg::NODE_W-1:0] r_ancestor, n_ancestor;

    logic                           in_acc;
    logic [NW-1:0]                  a_slot, b_slot, cur_slot, rd_a_slot, rd_b_slot;
    logic [bl_lca_pkg::DEPTH_W-1:0] dep_hi, dep_lo;

    // Node slots of the incoming word, the walking ancestor and the read data.
    assign a_slot    = NW'(bl_lca_pkg::node_slot(i_in.node_a, NODE_COUNT));
    assign b_slot    = NW'(bl_lca_pkg::node_slot(i_in.node_b, NODE_COUNT));
    assign cur_slot  = NW'(bl_lca_pkg::node_slot(r_cur, NODE_COUNT));
    assign rd_a_slot = NW'(bl_lca_pkg::node_slot(r_tbl_rd_a, NODE_COUNT));
    assign rd_b_slot = NW'(bl_lca_pkg::node_slot(r_tbl_rd_b, NODE_COUNT));

    // Handshake of both channels.
    assign i_in.ready     = (r_state == ST_IDLE);
    assign in_acc         = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.ancestor = r_ancestor;

    // Depth order of the two query nodes.
    assign dep_hi = (r_dep_rd_a < r_dep_rd_b) ? r_dep_rd_b : r_dep_rd_a;
    assign dep_lo = (r_dep_rd_a < r_dep_rd_b) ? r_dep_rd_a : r_dep_rd_b;

    // Memory ports: writes only during an add, reads follow the walk.
    assign tbl_we      = (r_state == ST_ADD_WR);
    assign tbl_waddr   = tbl_addr(r_node, r_lvl);
    assign tbl_wdata   = r_cur;
    assign tbl_raddr_a = (r_state == ST_ADD_WR) ? tbl_addr(cur_slot, r_lvl)
                                                : tbl_addr(r_u, r_lvl);
    assign tbl_raddr_b = tbl_addr(r_v, r_lvl);
    assign dep_we      = in_acc && (i_in.kind == bl_lca_pkg::KIND_ADD);

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            mem_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rd_a <= mem_tbl[tbl_raddr_a];
        r_tbl_rd_b <= mem_tbl[tbl_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            mem_dep[a_slot] <= i_in.node_depth;
        end
        r_dep_rd_a <= mem_dep[a_slot];
        r_dep_rd_b <= mem_dep[b_slot];
    end

    // Sequencer: next state and next register values.
    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_node      = r_node;
        n_cur       = r_cur;
        n_fwd       = r_fwd;
        n_u         = r_u;
        n_v         = r_v;
        n_diff      = r_diff;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_ancestor  = r_ancestor;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_lvl  = '0;
                    n_node = a_slot;
                    n_cur  = i_in.node_b;
                    n_u    = a_slot;
                    n_v    = b_slot;
                    if (i_in.kind == bl_lca_pkg::KIND_ADD) begin
                        n_state = ST_ADD_WR;
                    end else begin
                        n_state = ST_DEPTH_WAIT;
                    end
                end
            end
            ST_ADD_WR: begin
                // The entry is written now; its own row may be read, so forward.
                n_fwd = (cur_slot == r_node);
                if (r_lvl == LVL_TOP) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_ADD_WAIT;
                end
            end
            ST_ADD_WAIT: begin
                n_cur   = r_fwd ? r_cur : r_tbl_rd_a;
                n_lvl   = r_lvl + LVL_ONE;
                n_state = ST_ADD_WR;
            end
            ST_DEPTH_WAIT: begin
                if (r_dep_rd_a < r_dep_rd_b) begin
                    n_u = r_v;
                    n_v = r_u;
                end
                n_diff  = LEVELS'(dep_hi - dep_lo);
                n_lvl   = LVL_TOP;
                n_state = ST_LIFT;
            end
            ST_LIFT: begin
                if (r_diff[r_lvl]) begin
                    n_state = ST_LIFT_WAIT;
                end else if (r_lvl == '0) begin
                    n_state = ST_CHECK;
                end else begin
                    n_lvl = r_lvl - LVL_ONE;
                end
            end
            ST_LIFT_WAIT: begin
                n_u = rd_a_slot;
                if (r_lvl == '0) begin
                    n_state = ST_CHECK;
                end else begin
                    n_lvl   = r_lvl - LVL_ONE;
                    n_state = ST_LIFT;
                end
            end
            ST_CHECK: begin
                if (r_u == r_v) begin
                    n_res   = bl_lca_pkg::NODE_W'(r_u);
                    n_state = ST_DONE;
                end else begin
                    n_lvl   = LVL_TOP;
                    n_state = ST_DESC;
                end
            end
            ST_DESC: begin
                n_state = ST_DESC_WAIT;
            end
            ST_DESC_WAIT: begin
                // Both climb only where their ancestors at this level differ.
                if (r_tbl_rd_a != r_tbl_rd_b) begin
                    n_u = rd_a_slot;
                    n_v = rd_b_slot;
                end
                if (r_lvl == '0) begin
                    n_state = ST_FINAL_RD;
                end else begin
                    n_lvl   = r_lvl - LVL_ONE;
                    n_state = ST_DESC;
                end
            end
            ST_FINAL_RD: begin
                n_state = ST_FINAL_WAIT;
            end
            ST_FINAL_WAIT: begin
                n_res   = r_tbl_rd_a;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_ancestor  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lvl      <= n_lvl;
        r_node     <= n_node;
        r_cur      <= n_cur;
        r_fwd      <= n_fwd;
        r_u        <= n_u;
        r_v        <= n_v;
        r_diff     <= n_diff;
        r_res      <= n_res;
        r_ancestor <= n_ancestor;
    end

    // An answer only ever enters the output register from the done state.
    `BL_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state) == ST_DONE, "answer appeared outside the done state")
    // A query word goes straight to the depth reads.
    `BL_ASSERT(a_query_start, in_acc && i_in.kind == bl_lca_pkg::KIND_QUERY |=> r_state == ST_DEPTH_WAIT, "query did not start with depth reads")
    // Writing the top level of a row ends the add.
    `BL_ASSERT(a_add_end, r_state == ST_ADD_WR && r_lvl == LVL_TOP |=> r_state == ST_IDLE, "add did not finish after its top level")
    // The descent at level zero always leads to the final parent read.
    `BL_ASSERT(a_desc_end, r_state == ST_DESC_WAIT && r_lvl == '0 |=> r_state == ST_FINAL_RD, "descent did not end at level zero")

endmodule
